// File: hw/rtl/undo_history_budget_tracker_defines.svh
// Assertion macros for the undo history budget tracker checks.
`ifndef UNDO_HISTORY_BUDGET_TRACKER_DEFINES_SVH
`define UNDO_HISTORY_BUDGET_TRACKER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define UHBT_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define UHBT_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/uhbt_pkg.sv
// Types and constants shared by the undo history budget tracker.
`timescale 1ns / 1ps
package uhbt_pkg;

  localparam int SIZE_W   = 31;
  localparam int TICK_W   = 64;
  localparam int COL_W    = 16;
  localparam int LINE_W   = 20;
  localparam int BUDGET_W = 21;
  localparam int IDLE_W   = 16;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 10;
  localparam int EVICT_W  = 11;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [SIZE_W-1:0] SIZE_MAX   = {SIZE_W{1'b1}};
  localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd1500;

  localparam logic REG_BUDGET = 1'b0;
  localparam logic REG_IDLE   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_UNDO   = 3'd1,
    CMD_REDO   = 3'd2,
    CMD_MARK   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_COALESCED = 2'd1,
    ST_REFUSED   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MERGE_WR,
    S_TRUNC_CHK,
    S_TRUNC_SUB,
    S_FULL_SUB,
    S_PUSH,
    S_SHRINK_CHK,
    S_SHRINK_SUB,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic simple;
    logic push_prep;
    logic rd_en;
    logic rd_base;
    logic merge_wr;
    logic trunc_sub;
    logic evict_sub;
    logic push_wr;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_append;
    logic merge_ok;
    logic trunc_more;
    logic full;
    logic shrink_more;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/uhbt_controller.sv
// Sequencer that steps one item through the history datapath.
`timescale 1ns / 1ps
module uhbt_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  uhbt_pkg::dp_stat_t sts,
  output uhbt_pkg::dp_cmd_t  ctl
);
  import uhbt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.is_append) begin
          ctl.simple = 1'b1;
          state_next = S_FINISH;
        end else if (sts.merge_ok) begin
          ctl.rd_en  = 1'b1;
          state_next = S_MERGE_WR;
        end else begin
          ctl.push_prep = 1'b1;
          state_next    = S_TRUNC_CHK;
        end
      end
      S_MERGE_WR: begin
        ctl.merge_wr = 1'b1;
        state_next   = S_SHRINK_CHK;
      end
      S_TRUNC_CHK: begin
        if (sts.trunc_more) begin
          ctl.rd_en  = 1'b1;
          state_next = S_TRUNC_SUB;
        end else if (sts.full) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_base = 1'b1;
          state_next  = S_FULL_SUB;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_TRUNC_SUB: begin
        ctl.trunc_sub = 1'b1;
        state_next    = S_TRUNC_CHK;
      end
      S_FULL_SUB: begin
        ctl.evict_sub = 1'b1;
        state_next    = S_PUSH;
      end
      S_PUSH: begin
        ctl.push_wr = 1'b1;
        state_next  = S_SHRINK_CHK;
      end
      S_SHRINK_CHK: begin
        if (sts.shrink_more) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_base = 1'b1;
          state_next  = S_SHRINK_SUB;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SHRINK_SUB: begin
        ctl.evict_sub = 1'b1;
        state_next    = S_SHRINK_CHK;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/uhbt_datapath.sv
// History store, bookkeeping registers, config registers and result register.
`timescale 1ns / 1ps
module uhbt_datapath #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  uhbt_pkg::dp_cmd_t               ctl,
  output uhbt_pkg::dp_stat_t              sts,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [uhbt_pkg::APB_AW-1:0]     paddr,
  input  logic [uhbt_pkg::APB_DW-1:0]     pwdata,
  output logic [uhbt_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  input  logic [uhbt_pkg::CMD_W-1:0]      command,
  input  logic [uhbt_pkg::SIZE_W-1:0]     block_bytes,
  input  logic [uhbt_pkg::SIZE_W-1:0]     merge_bytes,
  input  logic                            single_insert,
  input  logic                            has_break,
  input  logic [uhbt_pkg::TICK_W-1:0]     now_ms,
  input  logic [uhbt_pkg::COL_W-1:0]      before_col,
  input  logic [uhbt_pkg::LINE_W-1:0]     before_line,
  input  logic [uhbt_pkg::COL_W-1:0]      after_col,
  input  logic [uhbt_pkg::LINE_W-1:0]     after_line,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [uhbt_pkg::STATUS_W-1:0]   status,
  output logic [uhbt_pkg::INDEX_W-1:0]    entry_index,
  output logic                            modified,
  output logic                            can_undo,
  output logic                            can_redo,
  output logic [uhbt_pkg::EVICT_W-1:0]    evicted_count,
  output logic                            saved_valid
);
  import uhbt_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] b, input logic [CW-1:0] lg);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(lg);
    if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_W] ? SIZE_MAX : s[SIZE_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_sub(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // config registers
  logic [BUDGET_W-1:0] budget_kb;
  logic [IDLE_W-1:0]   idle_limit_ms;

  // latched item
  logic [CMD_W-1:0]  cmd_q;
  logic [SIZE_W-1:0] block_q;
  logic [SIZE_W-1:0] merge_q;
  logic              word_q;
  logic [TICK_W-1:0] now_q;
  logic [COL_W-1:0]  bcol_q;
  logic [LINE_W-1:0] bline_q;
  logic [COL_W-1:0]  acol_q;
  logic [LINE_W-1:0] aline_q;

  // history state
  logic [AW-1:0]     ring_base;
  logic [CW-1:0]     entry_count;
  logic [CW-1:0]     cursor;
  logic [CW-1:0]     saved_pos;
  logic              saved_ok;
  logic [SIZE_W-1:0] total_size;
  logic              tail_open;
  logic [TICK_W-1:0] tail_tick;
  logic [COL_W-1:0]  tail_col;
  logic [LINE_W-1:0] tail_line;

  // per-item result bookkeeping
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]       res_index;
  logic                res_mod;
  logic [CW-1:0]       evicted;

  logic [SIZE_W-1:0] mem [HISTORY_DEPTH];
  logic [SIZE_W-1:0] rdata;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [SIZE_W-1:0] wr_data;
  logic              mem_we;

  logic [CW-1:0]     count_dec;
  logic [CW-1:0]     cursor_dec;
  logic [CW-1:0]     cursor_inc;
  logic [TICK_W-1:0] gap;
  logic [CW-1:0]     idx_cw;
  logic [CW+INDEX_W-1:0] idx_wide;
  logic [CW+EVICT_W-1:0] ev_wide;
  logic              cfg_we;

  assign count_dec  = entry_count - ONE_C;
  assign cursor_dec = cursor - ONE_C;
  assign cursor_inc = cursor + ONE_C;
  assign gap        = now_q - tail_tick;

  assign rd_addr = ctl.rd_base ? ring_base : slot_of(ring_base, count_dec);
  assign mem_we  = ctl.merge_wr | ctl.push_wr;
  assign wr_addr = ctl.merge_wr ? slot_of(ring_base, count_dec)
                                : slot_of(ring_base, entry_count);
  assign wr_data = ctl.merge_wr ? sat_add(rdata, merge_q) : block_q;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    sts.is_append   = (cmd_q == CMD_APPEND);
    sts.merge_ok    = word_q && (entry_count != '0) && (cursor != '0) &&
                      (cursor == entry_count) && tail_open &&
                      (gap <= TICK_W'(idle_limit_ms)) &&
                      (tail_col == bcol_q) && (tail_line == bline_q);
    sts.trunc_more  = (cursor < entry_count);
    sts.full        = (entry_count >= DEPTH_C);
    sts.shrink_more = (budget_kb != '0) && (total_size > {budget_kb, 10'b0}) &&
                      (cursor != '0);
    sts.out_free    = !out_valid || !out_stall;
  end

  // configuration port
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDLE) ? APB_DW'(idle_limit_ms) : APB_DW'(budget_kb);

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_kb     <= '0;
      idle_limit_ms <= IDLE_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_IDLE) begin
        idle_limit_ms <= pwdata[IDLE_W-1:0];
      end else begin
        budget_kb <= pwdata[BUDGET_W-1:0];
      end
    end
  end

  // item latch and result bookkeeping
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q      <= command;
      block_q    <= block_bytes;
      merge_q    <= merge_bytes;
      word_q     <= single_insert && !has_break;
      now_q      <= now_ms;
      bcol_q     <= before_col;
      bline_q    <= before_line;
      acol_q     <= after_col;
      aline_q    <= after_line;
      res_status <= ST_DONE;
      res_index  <= '0;
      res_mod    <= 1'b0;
      evicted    <= '0;
    end else begin
      if (ctl.simple) begin
        case (cmd_q) inside
          CMD_UNDO: begin
            if (entry_count != '0 && cursor != '0) begin
              res_index <= cursor_dec;
              res_mod   <= !(saved_ok && cursor_dec == saved_pos);
            end else begin
              res_status <= ST_REFUSED;
            end
          end
          CMD_REDO: begin
            if (entry_count != '0 && cursor < entry_count) begin
              res_index <= cursor;
              res_mod   <= !(saved_ok && cursor_inc == saved_pos);
            end else begin
              res_status <= ST_REFUSED;
            end
          end
          CMD_MARK, CMD_CLEAR: begin
            res_status <= ST_DONE;
          end
          default: begin
            res_status <= ST_REFUSED;
          end
        endcase
      end
      if (ctl.merge_wr) begin
        res_status <= ST_COALESCED;
      end
      if (ctl.evict_sub) begin
        evicted <= evicted + ONE_C;
      end
    end
  end

  // history bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base   <= '0;
      entry_count <= '0;
      cursor      <= '0;
      saved_pos   <= '0;
      saved_ok    <= 1'b1;
      total_size  <= '0;
      tail_open   <= 1'b0;
      tail_tick   <= '0;
      tail_col    <= '0;
      tail_line   <= '0;
    end else begin
      if (ctl.simple) begin
        case (cmd_q)
          CMD_UNDO: begin
            if (entry_count != '0 && cursor != '0) begin
              cursor <= cursor_dec;
            end
          end
          CMD_REDO: begin
            if (entry_count != '0 && cursor < entry_count) begin
              cursor <= cursor_inc;
            end
          end
          CMD_MARK: begin
            saved_pos <= cursor;
            saved_ok  <= 1'b1;
          end
          CMD_CLEAR: begin
            ring_base   <= '0;
            entry_count <= '0;
            cursor      <= '0;
            saved_pos   <= '0;
            saved_ok    <= 1'b1;
            total_size  <= '0;
            tail_open   <= 1'b0;
          end
          default: begin
            tail_open <= tail_open;
          end
        endcase
      end
      if (ctl.merge_wr) begin
        total_size <= sat_add(total_size, merge_q);
        tail_tick  <= now_q;
        tail_col   <= acol_q;
        tail_line  <= aline_q;
      end
      if (ctl.push_prep) begin
        tail_open <= word_q;
        if (word_q) begin
          tail_tick <= now_q;
        end
        tail_col  <= acol_q;
        tail_line <= aline_q;
      end
      if (ctl.trunc_sub) begin
        total_size  <= clamp_sub(total_size, rdata);
        entry_count <= count_dec;
      end
      if (ctl.evict_sub) begin
        total_size  <= clamp_sub(total_size, rdata);
        ring_base   <= slot_of(ring_base, ONE_C);
        entry_count <= count_dec;
        cursor      <= cursor_dec;
        if (saved_ok && saved_pos > ONE_C) begin
          saved_pos <= saved_pos - ONE_C;
        end else begin
          saved_ok <= 1'b0;
        end
      end
      if (ctl.push_wr) begin
        entry_count <= entry_count + ONE_C;
        cursor      <= entry_count + ONE_C;
        total_size  <= sat_add(total_size, block_q);
      end
    end
  end

  // result register
  always_comb begin
    if (cmd_q == CMD_APPEND) begin
      idx_cw = (entry_count != '0) ? count_dec : '0;
    end else begin
      idx_cw = res_index;
    end
    idx_wide = {{INDEX_W{1'b0}}, idx_cw};
    ev_wide  = {{EVICT_W{1'b0}}, evicted};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      status        <= res_status;
      entry_index   <= idx_wide[INDEX_W-1:0];
      modified      <= res_mod;
      can_undo      <= (entry_count != '0) && (cursor != '0);
      can_redo      <= (entry_count != '0) && (cursor < entry_count);
      evicted_count <= ev_wide[EVICT_W-1:0];
      saved_valid   <= saved_ok;
    end
  end

endmodule

// File: hw/rtl/undo_history_budget_tracker.sv
// Top level of the undo history budget tracker.
// Undo, redo, mark, clear and unknown commands go from decide to finish, which registers the result.
// Append: coalesce or push (after dropping redo entries and one eviction if full), then budget evictions.
// One item at a time: the next is accepted only in idle, after the result of the last is registered.
// The store walk (one read of the history memory per dropped or evicted entry) sets append time.
// Reset: synchronous; history empties, budget 0, idle limit 1500; no clearing pass of the store.
`timescale 1ns / 1ps
module undo_history_budget_tracker #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [uhbt_pkg::APB_AW-1:0]     paddr,
  input  logic [uhbt_pkg::APB_DW-1:0]     pwdata,
  output logic [uhbt_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [uhbt_pkg::CMD_W-1:0]      command,
  input  logic [uhbt_pkg::SIZE_W-1:0]     block_bytes,
  input  logic [uhbt_pkg::SIZE_W-1:0]     merge_bytes,
  input  logic                            single_insert,
  input  logic                            has_break,
  input  logic [uhbt_pkg::TICK_W-1:0]     now_ms,
  input  logic [uhbt_pkg::COL_W-1:0]      before_col,
  input  logic [uhbt_pkg::LINE_W-1:0]     before_line,
  input  logic [uhbt_pkg::COL_W-1:0]      after_col,
  input  logic [uhbt_pkg::LINE_W-1:0]     after_line,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [uhbt_pkg::STATUS_W-1:0]   status,
  output logic [uhbt_pkg::INDEX_W-1:0]    entry_index,
  output logic                            modified,
  output logic                            can_undo,
  output logic                            can_redo,
  output logic [uhbt_pkg::EVICT_W-1:0]    evicted_count,
  output logic                            saved_valid
);
  import uhbt_pkg::*;

  // Commands from the sequencer and conditions back from the datapath.
  dp_cmd_t  ctl;
  dp_stat_t sts;

  // Sequencer: accept in idle, decide coalesce or push, walk the store for
  // dropped redo entries and evictions, then hand the result to the output.
  uhbt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: size memory, cursor and saved mark, budget compare, result register.
  uhbt_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .command       (command),
    .block_bytes   (block_bytes),
    .merge_bytes   (merge_bytes),
    .single_insert (single_insert),
    .has_break     (has_break),
    .now_ms        (now_ms),
    .before_col    (before_col),
    .before_line   (before_line),
    .after_col     (after_col),
    .after_line    (after_line),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .entry_index   (entry_index),
    .modified      (modified),
    .can_undo      (can_undo),
    .can_redo      (can_redo),
    .evicted_count (evicted_count),
    .saved_valid   (saved_valid)
  );

endmodule

// File: hw/rtl/uhbt_checker.sv
// Port-level checks for the undo history budget tracker, bound to the top level.
`timescale 1ns / 1ps
`include "undo_history_budget_tracker_defines.svh"
module uhbt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [uhbt_pkg::STATUS_W-1:0] status,
  input logic [uhbt_pkg::INDEX_W-1:0]  entry_index,
  input logic                          can_redo,
  input logic [uhbt_pkg::EVICT_W-1:0]  evicted_count
);
  import uhbt_pkg::*;

  // A held result keeps its payload.
  `UHBT_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_index), "result changed while stalled")
  // One item in flight: the block stalls right after an accept.
  `UHBT_CHECK(a_one_item, in_valid && !in_stall |=> in_stall, "second item accepted while busy")
  // A refused command never evicts.
  `UHBT_CHECK(a_refuse_no_evict, out_valid && status == ST_REFUSED |-> evicted_count == '0, "refused item evicted entries")
  // A coalesced edit leaves the cursor at the end of history.
  `UHBT_CHECK(a_merge_no_redo, out_valid && status == ST_COALESCED |-> !can_redo, "redo left after coalesce")

endmodule

bind undo_history_budget_tracker uhbt_checker u_uhbt_checker (.*);

// File: tb/undo_history_budget_tracker_tb.sv
// Self-checking testbench for the undo history budget tracker.
`timescale 1ns / 1ps
module undo_history_budget_tracker_tb;
  import uhbt_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [APB_AW-1:0] ADDR_BUDGET = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_IDLE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
  localparam logic [SIZE_W-1:0] SMAX = SIZE_MAX;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] blk;
    logic [SIZE_W-1:0] mrg;
    logic              single;
    logic              brk;
    logic [TICK_W-1:0] now;
    logic [COL_W-1:0]  bcol;
    logic [LINE_W-1:0] bline;
    logic [COL_W-1:0]  acol;
    logic [LINE_W-1:0] aline;
  } edit_t;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [INDEX_W-1:0]  idx;
    logic                modf;
    logic                cu;
    logic                cr;
    logic [EVICT_W-1:0]  ev;
    logic                sv;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  edit_t drv = '0;
  outcome_t got;

  undo_history_budget_tracker DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(drv.cmd), .block_bytes(drv.blk), .merge_bytes(drv.mrg),
    .single_insert(drv.single), .has_break(drv.brk), .now_ms(drv.now),
    .before_col(drv.bcol), .before_line(drv.bline),
    .after_col(drv.acol), .after_line(drv.aline),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(got.st), .entry_index(got.idx), .modified(got.modf),
    .can_undo(got.cu), .can_redo(got.cr), .evicted_count(got.ev),
    .saved_valid(got.sv)
  );

  // Pending edits for the driver and outcomes awaited by the monitor.
  edit_t pending_edits[$];
  outcome_t awaited_outcomes[$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int edits_sent = 0;
  int outcomes_seen = 0;
  int coalesces_seen = 0;
  int evictions_seen = 0;
  int refusals_seen = 0;
  longint cycles = 0;

  // History shadow: sizes, ring, cursor, saved mark, coalescing tail.
  logic [SIZE_W-1:0]   hist_size[DEPTH];
  int unsigned         hist_base, hist_count, hist_cursor, hist_saved;
  logic                hist_saved_ok, hist_tail_open;
  logic [SIZE_W-1:0]   hist_total;
  logic [TICK_W-1:0]   hist_tick;
  logic [COL_W-1:0]    hist_col;
  logic [LINE_W-1:0]   hist_line;
  logic [BUDGET_W-1:0] cfg_budget;
  logic [IDLE_W-1:0]   cfg_idle;

  // Generator chain: caret and tick of the last generated append.
  logic [COL_W-1:0]  chain_col;
  logic [LINE_W-1:0] chain_line;
  logic [TICK_W-1:0] chain_tick;

  initial begin
    hist_base = 0; hist_count = 0; hist_cursor = 0; hist_saved = 0;
    hist_saved_ok = 1'b1; hist_tail_open = 1'b0; hist_total = '0;
    hist_tick = '0; hist_col = '0; hist_line = '0;
    cfg_budget = '0; cfg_idle = IDLE_RESET;
    chain_col = '0; chain_line = '0; chain_tick = '0;
  end

  // Queue an edit at the back of the pending list.
  function automatic void add_edit(edit_t e);
    pending_edits.insert(pending_edits.size(), e);
  endfunction

  function automatic logic [SIZE_W-1:0] sat_add(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SIZE_W] ? SMAX : s[SIZE_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_sub(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic int unsigned ring_slot(int unsigned logical);
    return (hist_base + logical) % DEPTH;
  endfunction

  // Drop the n oldest entries and rebase the saved mark.
  function automatic void drop_oldest(int unsigned n);
    hist_base = (hist_base + n) % DEPTH;
    hist_count -= n;
    hist_cursor -= n;
    if (hist_saved_ok && hist_saved > n) hist_saved -= n;
    else hist_saved_ok = 1'b0;
  endfunction

  // Evict oldest undo entries while the total is over budget.
  function automatic int unsigned enforce_budget();
    longint unsigned limit;
    int unsigned n;
    logic [SIZE_W-1:0] size;
    n = 0;
    size = hist_total;
    if (cfg_budget == 0) return 0;
    limit = longint'(cfg_budget) * 1024;
    if (limit > SMAX) limit = SMAX;
    while (size > limit && n < hist_cursor && n < hist_count) begin
      size = clamp_sub(size, hist_size[ring_slot(n)]);
      n++;
    end
    if (n == 0) return 0;
    hist_total = size;
    drop_oldest(n);
    return n;
  endfunction

  // Advance the shadow history by one edit and return what the block should report.
  function automatic outcome_t apply_edit(edit_t e);
    outcome_t r;
    logic word, merge;
    int unsigned s, evicted;
    r = '0;
    evicted = 0;
    case (e.cmd)
      CMD_APPEND: begin
        word = e.single && !e.brk;
        merge = word && hist_count > 0 && hist_cursor > 0 && hist_cursor == hist_count &&
                hist_tail_open && (e.now - hist_tick) <= {48'd0, cfg_idle} &&
                hist_col == e.bcol && hist_line == e.bline;
        if (merge) begin
          s = ring_slot(hist_count - 1);
          hist_size[s] = sat_add(hist_size[s], e.mrg);
          hist_total = sat_add(hist_total, e.mrg);
          hist_tick = e.now;
          hist_col = e.acol;
          hist_line = e.aline;
          r.st = ST_COALESCED;
        end else begin
          // drop redo entries, evict the oldest if full, then push
          for (int unsigned i = hist_cursor; i < hist_count; i++)
            hist_total = clamp_sub(hist_total, hist_size[ring_slot(i)]);
          if (hist_cursor < hist_count) hist_count = hist_cursor;
          hist_tail_open = word;
          if (word) hist_tick = e.now;
          hist_col = e.acol;
          hist_line = e.aline;
          if (hist_count >= DEPTH) begin
            hist_total = clamp_sub(hist_total, hist_size[ring_slot(0)]);
            drop_oldest(1);
            evicted = 1;
          end
          hist_size[ring_slot(hist_count)] = e.blk;
          hist_count++;
          hist_cursor = hist_count;
          hist_total = sat_add(hist_total, e.blk);
          r.st = ST_DONE;
        end
        evicted += enforce_budget();
        r.idx = (hist_count > 0) ? INDEX_W'(hist_count - 1) : '0;
      end
      CMD_UNDO: begin
        if (hist_count > 0 && hist_cursor > 0) begin
          hist_cursor--;
          r.modf = !(hist_saved_ok && hist_cursor == hist_saved);
          r.idx = INDEX_W'(hist_cursor);
        end else r.st = ST_REFUSED;
      end
      CMD_REDO: begin
        if (hist_count > 0 && hist_cursor < hist_count) begin
          r.idx = INDEX_W'(hist_cursor);
          hist_cursor++;
          r.modf = !(hist_saved_ok && hist_cursor == hist_saved);
        end else r.st = ST_REFUSED;
      end
      CMD_MARK: begin
        hist_saved = hist_cursor;
        hist_saved_ok = 1'b1;
      end
      CMD_CLEAR: begin
        hist_base = 0; hist_count = 0; hist_cursor = 0; hist_saved = 0;
        hist_saved_ok = 1'b1; hist_total = '0; hist_tail_open = 1'b0;
      end
      default: r.st = ST_REFUSED;
    endcase
    r.cu = hist_count > 0 && hist_cursor > 0;
    r.cr = hist_count > 0 && hist_cursor < hist_count;
    r.ev = EVICT_W'(evicted);
    r.sv = hist_saved_ok;
    return r;
  endfunction

  function automatic edit_t make_append(logic [SIZE_W-1:0] blk, logic [SIZE_W-1:0] mrg,
                                        logic si, logic hb, logic [TICK_W-1:0] now,
                                        logic [COL_W-1:0] bc, logic [LINE_W-1:0] bl,
                                        logic [COL_W-1:0] ac, logic [LINE_W-1:0] al);
    edit_t e;
    e = '{cmd: CMD_APPEND, blk: blk, mrg: mrg, single: si, brk: hb, now: now,
          bcol: bc, bline: bl, acol: ac, aline: al};
    return e;
  endfunction

  function automatic edit_t make_cmd(logic [CMD_W-1:0] c);
    edit_t e;
    e = '0;
    e.cmd = c;
    e.blk = SIZE_W'($urandom());
    e.now = {$urandom(), $urandom()};
    return e;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int p;
    p = $urandom_range(99);
    if (p < 80) return SIZE_W'($urandom_range(1500));
    if (p < 95) return SIZE_W'($urandom());
    return (p < 97) ? '0 : SMAX;
  endfunction

  // Mostly typing runs that coalesce; the rest other edits, moves and noise.
  function automatic edit_t rand_edit();
    edit_t e;
    int p;
    p = $urandom_range(99);
    if (p < 55) begin
      e = make_append(rand_size(), rand_size(), 1'b1, 1'b0, '0, chain_col, chain_line, '0, '0);
      e.now = chain_tick + TICK_W'($urandom_range(($urandom_range(9) == 0) ? 70000 : 1400));
      if ($urandom_range(19) == 0) e.now = {$urandom(), $urandom()};
      if ($urandom_range(9) == 0) begin
        e.bcol = COL_W'($urandom());
        e.bline = LINE_W'($urandom());
      end
      e.acol = e.bcol + 1'b1;
      e.aline = ($urandom_range(29) == 0) ? LINE_W'($urandom()) : e.bline;
    end else if (p < 70) begin
      e = make_append(rand_size(), rand_size(), 1'($urandom()), 1'($urandom()),
                      {$urandom(), $urandom()}, COL_W'($urandom()), LINE_W'($urandom()),
                      COL_W'($urandom()), LINE_W'($urandom()));
      e.now = ($urandom_range(1)) ? e.now : chain_tick + TICK_W'($urandom_range(3000));
    end else if (p < 82) e = make_cmd(CMD_UNDO);
    else if (p < 91) e = make_cmd(CMD_REDO);
    else if (p < 95) e = make_cmd(CMD_MARK);
    else if (p < 97) e = make_cmd(CMD_CLEAR);
    else e = make_cmd(CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)));
    if (e.cmd == CMD_APPEND) begin
      chain_col = e.acol;
      chain_line = e.aline;
      chain_tick = e.now;
    end
    return e;
  endfunction

  // Clock and cycle guard.
  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outcomes still awaited", cycles,
               awaited_outcomes.size());
      $display("undo_history_budget_tracker_tb: FAIL");
      $finish;
    end
  end

  // Driver: on accept, predict the outcome; then load the next item or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        awaited_outcomes.insert(awaited_outcomes.size(), apply_edit(drv));
        edits_sent++;
      end
      if (pending_edits.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        drv <= pending_edits.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: randomize the stall and check each accepted result item.
  always @(posedge clk) begin
    outcome_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      outcomes_seen++;
      if (got.st == ST_COALESCED) coalesces_seen++;
      if (got.st == ST_REFUSED) refusals_seen++;
      evictions_seen += got.ev;
      if (awaited_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = awaited_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: expected %p, got %p", cycles, want, got);
        end
      end
    end
  end

  // Write a register through the APB port and mirror it in the shadow config.
  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_BUDGET) cfg_budget = data[BUDGET_W-1:0];
    else cfg_idle = data[IDLE_W-1:0];
  endtask

  // Hold until every item is sent and every result has come back.
  task automatic drain();
    while (pending_edits.size() > 0 || in_valid || awaited_outcomes.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) add_edit(rand_edit());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: refusals on empty history, coalescing, saturation, wrap, redo drop.
    write_reg(ADDR_BUDGET, '0);
    write_reg(ADDR_IDLE, 32'd1500);
    add_edit(make_cmd(CMD_UNDO));
    add_edit(make_cmd(CMD_REDO));
    add_edit(make_cmd(CMD_MARK));
    add_edit(make_cmd(CMD_BAD_HI));
    add_edit(make_append('0, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    add_edit(make_append(10, 5, 1'b1, 1'b0, 64'd100, 0, 0, 1, 0));
    add_edit(make_append(99, 7, 1'b1, 1'b0, 64'd200, 1, 0, 2, 0));
    add_edit(make_append(1, SMAX, 1'b1, 1'b0, 64'd1700, 2, 0, 3, 0));
    add_edit(make_append(SMAX, 3, 1'b1, 1'b1, 64'd1701, 3, 0, 4, 0));
    add_edit(make_cmd(CMD_UNDO));
    add_edit(make_cmd(CMD_UNDO));
    add_edit(make_cmd(CMD_REDO));
    add_edit(make_cmd(CMD_REDO));
    add_edit(make_cmd(CMD_REDO));
    add_edit(make_cmd(CMD_MARK));
    add_edit(make_cmd(CMD_UNDO));
    add_edit(make_append(20, 0, 1'b0, 1'b1, '1, '1, '1, '1, '1));
    add_edit(make_cmd(CMD_CLEAR));
    add_edit(make_append(4, 4, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 9, 3, 10, 3));
    add_edit(make_append(4, 4, 1'b1, 1'b0, 64'h10, 10, 3, 11, 3));
    add_edit(make_append(4, 4, 1'b1, 1'b0, 64'd3000, 11, 3, 12, 3));
    drain();

    run_random(140, 0, 0);
    write_reg(ADDR_BUDGET, 32'd1);
    write_reg(ADDR_IDLE, 32'd0);
    run_random(140, 50, 0);
    write_reg(ADDR_BUDGET, 32'd2097151);
    write_reg(ADDR_IDLE, 32'd65535);
    run_random(140, 0, 50);
    write_reg(ADDR_BUDGET, 32'd3);
    write_reg(ADDR_IDLE, 32'd200);
    run_random(140, 22, 22);

    // Build a long undo history with no budget.
    write_reg(ADDR_BUDGET, '0);
    write_reg(ADDR_IDLE, 32'd1500);
    add_edit(make_cmd(CMD_CLEAR));
    add_edit(make_cmd(CMD_MARK));
    for (int i = 0; i < 40; i++)
      add_edit(make_append(rand_size(), '0, 1'b1, 1'b1, 64'(i),
                           COL_W'(i), 0, COL_W'(i + 1), 0));
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    // A tight budget now evicts most of the history in one step.
    write_reg(ADDR_BUDGET, 32'd1);
    run_random(30, 22, 22);

    $display("sent %0d items, checked %0d results: %0d coalesced, %0d refused",
             edits_sent, outcomes_seen, coalesces_seen, refusals_seen);
    $display("%0d entries evicted, %0d mismatches", evictions_seen, mismatches);
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("undo_history_budget_tracker_tb: PASS");
    end else begin
      $display("undo_history_budget_tracker_tb: FAIL");
    end
    $finish;
  end

endmodule
